[src/sios_pkg.sv]
package sios_pkg;

  // Item mode codes on the input channel.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Field widths of one reference or query interval, and the overlap count width.
  localparam int unsigned SEQ_W = 12;
  localparam int unsigned POS_W = 32;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned ENT_W = SEQ_W + 2 * POS_W;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic start;
    logic advance;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode_load;
    logic mode_clear;
    logic mode_query;
    logic skip;
    logic slot_free;
  } sts_t;

endpackage

[src/sios_in_if.sv]
interface sios_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [11:0] seq_id;
  logic signed [31:0] range_start;
  logic signed [31:0] range_end;

  modport source (
    output valid, mode, seq_id, range_start, range_end,
    input  ready
  );
  modport sink (
    input  valid, mode, seq_id, range_start, range_end,
    output ready
  );
endinterface

[src/sios_out_if.sv]
interface sios_out_if;
  logic        valid;
  logic        ready;
  logic        overlaps;
  logic [31:0] overlap_total;
  logic        store_overflow;

  modport source (
    output valid, overlaps, overlap_total, store_overflow,
    input  ready
  );
  modport sink (
    input  valid, overlaps, overlap_total, store_overflow,
    output ready
  );
endinterface

[src/sorted_interval_overlap_sweep_top.sv]
// Sorted interval overlap sweep.
// Channel in_ch takes items with a mode: load appends a reference interval
// (seq_id, range_start, range_end) to the store, clear empties the store and
// zeroes the sweep pointer, the overlap count and the overflow flag, query
// checks one interval against the store. Mode three is taken and ignored.
// References and queries are expected sorted by seq_id, then by start.
// Channel out_ch gives one item per query: overlaps, the saturating running
// overlap_total and the sticky store_overflow. Loads and clears give none.
// A query sweeps the store: the sweep pointer walks the store through its
// single registered read port and never moves back, so over a run it steps
// over at most the number of references loaded. The result is loaded into
// the output register at the edge that ends the sweep. If the receiver
// stalls, the next item is still taken; a following query sweeps and then
// holds until the output register is free.
// Reset clears the control state and the counts; the store needs no
// clearing pass since only entries below the fill count are read.
module sorted_interval_overlap_sweep_top #(
  parameter int unsigned REF_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  sios_in_if.sink      in_ch,
  sios_out_if.source   out_ch
);

  sios_pkg::cmd_t cmd;
  sios_pkg::sts_t sts;

  // Controller.
  sios_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath with the reference store.
  sios_dp #(
    .REF_DEPTH (REF_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .mode           (in_ch.mode),
    .seq_id         (in_ch.seq_id),
    .range_start    (in_ch.range_start),
    .range_end      (in_ch.range_end),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .overlaps       (out_ch.overlaps),
    .overlap_total  (out_ch.overlap_total),
    .store_overflow (out_ch.store_overflow),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

[src/sios_ram.sv]
module sios_ram #(
  parameter int unsigned WIDTH = 76,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/sios_ctrl.sv]
module sios_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sios_pkg::sts_t sts,
  output sios_pkg::cmd_t cmd
);

  sios_pkg::state_t state;
  sios_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sios_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a query starts a sweep, which ends once its result is stored.
  always_comb begin
    state_next = state;
    case (state)
      sios_pkg::ST_IDLE: begin
        if (in_valid && sts.mode_query) begin
          state_next = sios_pkg::ST_SWEEP;
        end
      end
      sios_pkg::ST_SWEEP: begin
        if (!sts.skip && sts.slot_free) begin
          state_next = sios_pkg::ST_IDLE;
        end
      end
      default: state_next = sios_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      sios_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid && sts.mode_load;
        cmd.clear = in_valid && sts.mode_clear;
        cmd.start = in_valid && sts.mode_query;
      end
      sios_pkg::ST_SWEEP: begin
        cmd.advance = sts.skip;
        cmd.emit    = !sts.skip && sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[src/sios_dp.sv]
module sios_dp #(
  parameter int unsigned REF_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         mode,
  input  logic [11:0]        seq_id,
  input  logic signed [31:0] range_start,
  input  logic signed [31:0] range_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               overlaps,
  output logic [31:0]        overlap_total,
  output logic               store_overflow,
  input  sios_pkg::cmd_t     cmd,
  output sios_pkg::sts_t     sts
);

  localparam int unsigned AW = $clog2(REF_DEPTH);
  localparam int unsigned PW = $clog2(REF_DEPTH + 1);
  localparam int unsigned SW = sios_pkg::SEQ_W;
  localparam int unsigned XW = sios_pkg::POS_W;
  localparam int unsigned EW = sios_pkg::ENT_W;
  localparam int unsigned CW = sios_pkg::CNT_W;

  logic [SW-1:0]        q_seq;
  logic signed [XW-1:0] q_start;
  logic signed [XW-1:0] q_end;
  logic [PW-1:0]        ptr;
  logic [PW-1:0]        fill;
  logic [CW-1:0]        cnt;
  logic                 ovf;

  logic [PW-1:0]        ptr_next;
  logic [AW-1:0]        raddr;
  logic                 we;
  logic [EW-1:0]        rdata;
  logic [SW-1:0]        r_seq;
  logic signed [XW-1:0] r_start;
  logic signed [XW-1:0] r_end;
  logic                 ent_valid;
  logic                 hit;
  logic [CW-1:0]        cnt_next;

  // Mode decode of the item at the input.
  assign sts.mode_load  = (mode == sios_pkg::MODE_LOAD);
  assign sts.mode_clear = (mode == sios_pkg::MODE_CLEAR);
  assign sts.mode_query = (mode == sios_pkg::MODE_QUERY);

  // Reference store: appended at the fill count, read at the sweep pointer.
  assign we       = cmd.load && (fill < PW'(REF_DEPTH));
  assign ptr_next = ptr + PW'(1);
  assign raddr    = cmd.advance ? ptr_next[AW-1:0] : ptr[AW-1:0];

  sios_ram #(
    .WIDTH (EW),
    .DEPTH (REF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (fill[AW-1:0]),
    .wdata ({seq_id, range_start, range_end}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign r_seq   = rdata[EW-1 -: SW];
  assign r_start = rdata[2*XW-1 -: XW];
  assign r_end   = rdata[XW-1:0];

  // Compare the reference at the pointer against the held query.
  assign ent_valid = (ptr < fill);
  assign sts.skip  = ent_valid &&
                     ((r_seq < q_seq) || ((r_seq == q_seq) && (r_end <= q_start)));
  assign hit       = ent_valid && (r_seq == q_seq) && (r_start < q_end);
  assign sts.slot_free = !out_valid || out_ready;

  // Saturating count of overlapping queries.
  assign cnt_next = (hit && (cnt != '1)) ? cnt + CW'(1) : cnt;

  // Query holding registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_seq   <= seq_id;
      q_start <= range_start;
      q_end   <= range_end;
    end
  end

  // Fill count, sweep pointer, counter and overflow flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill <= '0;
      ptr  <= '0;
      cnt  <= '0;
      ovf  <= 1'b0;
    end else begin
      if (we) begin
        fill <= fill + PW'(1);
      end
      if (cmd.load && !we) begin
        ovf <= 1'b1;
      end
      if (cmd.advance) begin
        ptr <= ptr_next;
      end
      if (cmd.emit) begin
        cnt <= cnt_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      overlaps       <= hit;
      overlap_total  <= cnt_next;
      store_overflow <= ovf;
    end
  end

  // The pointer never passes the fill count, which never passes the depth.
  assert property (@(posedge clk) disable iff (rst) (ptr <= fill) && (fill <= PW'(REF_DEPTH)))
    else $error("sweep pointer or fill count out of range");

  // Commands are mutually exclusive.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.clear, cmd.start, cmd.advance, cmd.emit}))
    else $error("more than one datapath command at once");

  // A result is stored only into a free output slot and then shows up.
  assert property (@(posedge clk) disable iff (rst) cmd.emit |=> out_valid)
    else $error("stored result not presented");

  // The overflow flag is sticky until a clear.
  assert property (@(posedge clk) disable iff (rst) (ovf && !cmd.clear) |=> ovf)
    else $error("overflow flag dropped without a clear");

  // The pointer only moves forward by one, except on a clear.
  assert property (@(posedge clk) disable iff (rst)
    (!cmd.clear && !cmd.advance) |=> $stable(ptr))
    else $error("sweep pointer moved without a command");

endmodule
